// ===== rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse
// Matrix dimension, element count and result flag positions in tuser.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DIM   = 3;
    localparam int NELEM = DIM * DIM;

    // m_tuser bit positions
    localparam int USER_SINGULAR = 0;
    localparam int USER_CLIPPED  = 1;
    localparam int USER_W        = 2;

endpackage

// ===== rtl/mi3_cof.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof: cofactor stages
// Stage 1 forms the eighteen 2x2 minor products, stage 2 the nine cofactors.
// ----------------------------------------------------------------------------
module mi3_cof #(
    parameter int DW = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [mi3_pkg::NELEM-1:0][DW-1:0]    m,
    output logic                                 out_valid,
    output logic [mi3_pkg::NELEM-1:0][2*DW:0]    cof,
    output logic [mi3_pkg::DIM-1:0][DW-1:0]      row0
);
    import mi3_pkg::*;

    localparam int PW = 2 * DW;
    localparam int CW = 2 * DW + 1;

    logic signed [PW-1:0] pa_reg [NELEM];
    logic signed [PW-1:0] pb_reg [NELEM];
    logic [CW-1:0]        cof_reg [NELEM];
    logic [DW-1:0]        r0a_reg [DIM];
    logic [DW-1:0]        r0b_reg [DIM];
    logic                 v1_reg;
    logic                 v2_reg;

    for (genvar r = 0; r < DIM; r++) begin : g_row
        for (genvar c = 0; c < DIM; c++) begin : g_col
            localparam int K  = r * DIM + c;
            localparam int A0 = ((r + 1) % DIM) * DIM + (c + 1) % DIM;
            localparam int A1 = ((r + 2) % DIM) * DIM + (c + 2) % DIM;
            localparam int B0 = ((r + 1) % DIM) * DIM + (c + 2) % DIM;
            localparam int B1 = ((r + 2) % DIM) * DIM + (c + 1) % DIM;

            always_ff @(posedge aclk) begin
                if (en) begin
                    pa_reg[K]  <= $signed(m[A0]) * $signed(m[A1]);
                    pb_reg[K]  <= $signed(m[B0]) * $signed(m[B1]);
                    cof_reg[K] <= {pa_reg[K][PW-1], pa_reg[K]} - {pb_reg[K][PW-1], pb_reg[K]};
                end
            end

            assign cof[K] = cof_reg[K];
        end
    end

    for (genvar c = 0; c < DIM; c++) begin : g_r0
        always_ff @(posedge aclk) begin
            if (en) begin
                r0a_reg[c] <= m[c];
                r0b_reg[c] <= r0a_reg[c];
            end
        end
        assign row0[c] = r0b_reg[c];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;

endmodule

// ===== rtl/mi3_det.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det: determinant stages
// Expansion along row 0 in split partial products; cofactors delayed alongside.
// ----------------------------------------------------------------------------
module mi3_det #(
    parameter int DW = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [mi3_pkg::NELEM-1:0][2*DW:0]    cof,
    input  logic [mi3_pkg::DIM-1:0][DW-1:0]      row0,
    output logic                                 out_valid,
    output logic [3*DW+2:0]                      det,
    output logic [mi3_pkg::NELEM-1:0][2*DW:0]    cof_d
);
    import mi3_pkg::*;

    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;

    logic signed [2*DW:0]   ph_reg [DIM];
    logic signed [2*DW:0]   pl_reg [DIM];
    logic signed [DETW-1:0] term_reg [DIM];
    logic signed [DETW-1:0] det_reg;
    logic [CW-1:0]          cd1_reg [NELEM];
    logic [CW-1:0]          cd2_reg [NELEM];
    logic [CW-1:0]          cd3_reg [NELEM];
    logic [2:0]             v_reg;

    for (genvar c = 0; c < DIM; c++) begin : g_term
        logic signed [DETW-1:0] ph_x;
        logic signed [DETW-1:0] pl_x;

        assign ph_x = DETW'(ph_reg[c]);
        assign pl_x = DETW'(pl_reg[c]);

        always_ff @(posedge aclk) begin
            if (en) begin
                // high part keeps the sign, low part is unsigned
                ph_reg[c]   <= $signed(row0[c]) * $signed(cof[c][CW-1:DW]);
                pl_reg[c]   <= $signed(row0[c]) * $signed({1'b0, cof[c][DW-1:0]});
                term_reg[c] <= (ph_x <<< DW) + pl_x;
            end
        end
    end

    for (genvar k = 0; k < NELEM; k++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (en) begin
                cd1_reg[k] <= cof[k];
                cd2_reg[k] <= cd1_reg[k];
                cd3_reg[k] <= cd2_reg[k];
            end
        end
        assign cof_d[k] = cd3_reg[k];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign det       = det_reg;
    assign out_valid = v_reg[2];

endmodule

// ===== rtl/mi3_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div: pipelined divider lane
// Sign/magnitude, range check, one restoring quotient bit per stage, saturate.
// ----------------------------------------------------------------------------
module mi3_div #(
    parameter int DW = 32,
    parameter int FB = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [3*DW+2:0]  det,
    input  logic [2*DW:0]    cof,
    output logic             out_valid,
    output logic [DW-1:0]    res,
    output logic             singular,
    output logic             clip
);
    import mi3_pkg::*;

    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int NW   = CW + 2 * FB;
    localparam int DVW  = DETW + DW + 1;
    localparam int RW   = (NW > DVW) ? NW : DVW;
    localparam int NS   = DW + 1;

    localparam logic [NS-1:0] QPOS = {2'b00, {(DW - 1){1'b1}}};
    localparam logic [NS-1:0] QNEG = {2'b01, {(DW - 1){1'b0}}};

    logic [DETW-1:0] dmag_next;
    logic [CW-1:0]   cmag_next;

    logic [DETW-1:0] dmag0_reg;
    logic [RW-1:0]   nmag0_reg;
    logic            qneg0_reg;
    logic            sing0_reg;
    logic            v0_reg;

    logic [RW-1:0]   rem_reg [NS+1];
    logic [DETW-1:0] dv_reg  [NS+1];
    logic [NS-1:0]   q_reg   [NS+1];
    logic            ovf_reg [NS+1];
    logic            qn_reg  [NS+1];
    logic            sg_reg  [NS+1];
    logic            vd_reg  [NS+1];

    logic [DW-1:0]   res_next;
    logic            clip_next;
    logic [NS-1:0]   qfin;
    logic [DW-1:0]   res_reg;
    logic            clip_reg;
    logic            sing_reg;
    logic            vout_reg;

    assign dmag_next = det[DETW-1] ? (~det + 1'b1) : det;
    assign cmag_next = cof[CW-1] ? (~cof + 1'b1) : cof;

    always_ff @(posedge aclk) begin
        if (en) begin
            dmag0_reg <= dmag_next;
            nmag0_reg <= RW'(cmag_next) << (2 * FB);
            qneg0_reg <= cof[CW-1] ^ det[DETW-1];
            sing0_reg <= (det == '0);
            // range check: quotient needs more than NS bits
            rem_reg[0] <= nmag0_reg;
            dv_reg[0]  <= dmag0_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= nmag0_reg >= (RW'(dmag0_reg) << NS);
            qn_reg[0]  <= qneg0_reg;
            sg_reg[0]  <= sing0_reg;
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = NS - 1 - j;
        logic [RW-1:0] trial;
        logic          ge;

        assign trial = RW'(dv_reg[j]) << K;
        assign ge    = rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= ge ? (rem_reg[j] - trial) : rem_reg[j];
                q_reg[j+1]   <= {q_reg[j][NS-2:0], ge};
                dv_reg[j+1]  <= dv_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
                qn_reg[j+1]  <= qn_reg[j];
                sg_reg[j+1]  <= sg_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[j+1] <= 1'b0;
            end else if (en) begin
                vd_reg[j+1] <= vd_reg[j];
            end
        end
    end

    assign qfin = q_reg[NS];

    always_comb begin
        res_next  = '0;
        clip_next = 1'b0;
        if (sg_reg[NS]) begin
            res_next  = '0;
            clip_next = 1'b0;
        end else if (!qn_reg[NS]) begin
            clip_next = ovf_reg[NS] || (qfin > QPOS);
            res_next  = clip_next ? QPOS[DW-1:0] : qfin[DW-1:0];
        end else begin
            clip_next = ovf_reg[NS] || (qfin > QNEG);
            res_next  = clip_next ? QNEG[DW-1:0] : (~qfin[DW-1:0] + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg  <= res_next;
            clip_reg <= clip_next;
            sing_reg <= sg_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg    <= 1'b0;
            vd_reg[0] <= 1'b0;
            vout_reg  <= 1'b0;
        end else if (en) begin
            v0_reg    <= in_valid;
            vd_reg[0] <= v0_reg;
            vout_reg  <= vd_reg[NS];
        end
    end

    assign out_valid = vout_reg;
    assign res       = res_reg;
    assign singular  = sing_reg;
    assign clip      = clip_reg;

endmodule

// ===== rtl/matrix3_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse: pipelined 3x3 fixed-point matrix inverse by the adjugate
//
// channel  dir  payload
// -------  ---  --------------------------------------------------------------
// s_       in   tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22, DATA_WIDTH each
// m_       out  tdata: r00 .. r22, DATA_WIDTH each; tuser: singular, clipped
//
// One matrix per cycle sustained while the m_ side accepts results; the
// restoring divider lanes, one quotient bit per stage, make up most of the
// pipeline.
// Reset (aresetn, synchronous, active low) clears all valid bits.
// All stages advance together while the skid register is empty; a stalled
// m_ side parks one result in the skid, then s_tready drops (registered).
// ----------------------------------------------------------------------------
module matrix3_inverse #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (low to high), zero pad
    input  logic [((mi3_pkg::NELEM*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22 (low to high), zero pad
    output logic [((mi3_pkg::NELEM*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // singular, clipped (low to high)
    output logic [mi3_pkg::USER_W-1:0] m_tuser
);
    import mi3_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int CW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int SW   = ((NELEM * DW + 7) / 8) * 8;

    logic                         en;
    logic [NELEM-1:0][DW-1:0]     m_in;
    logic                         cof_valid;
    logic [NELEM-1:0][CW-1:0]     cof;
    logic [DIM-1:0][DW-1:0]       row0;
    logic                         det_valid;
    logic [DETW-1:0]              det;
    logic [NELEM-1:0][CW-1:0]     cof_d;
    logic [NELEM-1:0]             lane_valid;
    logic [NELEM-1:0]             lane_sing;
    logic [NELEM-1:0]             lane_clip;
    logic [NELEM-1:0][DW-1:0]     lane_res;
    logic                         tail_valid;
    logic [USER_W-1:0]            tail_user;

    logic                         out_valid_reg;
    logic [NELEM*DW-1:0]          out_data_reg;
    logic [USER_W-1:0]            out_user_reg;
    logic                         skid_valid_reg;
    logic [NELEM*DW-1:0]          skid_data_reg;
    logic [USER_W-1:0]            skid_user_reg;

    // whole pipeline moves unless a result is parked in the skid
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    for (genvar k = 0; k < NELEM; k++) begin : g_unpack
        assign m_in[k] = s_tdata[k*DW +: DW];
    end

    mi3_cof #(.DW(DW)) u_cof (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .m         (m_in),
        .out_valid (cof_valid),
        .cof       (cof),
        .row0      (row0)
    );

    mi3_det #(.DW(DW)) u_det (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cof_valid),
        .cof       (cof),
        .row0      (row0),
        .out_valid (det_valid),
        .det       (det),
        .cof_d     (cof_d)
    );

    // lane (r,c) divides cofactor (c,r): transpose into the adjugate
    for (genvar r = 0; r < DIM; r++) begin : g_lr
        for (genvar c = 0; c < DIM; c++) begin : g_lc
            mi3_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (en),
                .in_valid  (det_valid),
                .det       (det),
                .cof       (cof_d[c*DIM+r]),
                .out_valid (lane_valid[r*DIM+c]),
                .res       (lane_res[r*DIM+c]),
                .singular  (lane_sing[r*DIM+c]),
                .clip      (lane_clip[r*DIM+c])
            );
        end
    end

    assign tail_valid                = lane_valid[0];
    assign tail_user[USER_SINGULAR]  = lane_sing[0];
    assign tail_user[USER_CLIPPED]   = |lane_clip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || m_tready) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    out_data_reg   <= skid_data_reg;
                    out_user_reg   <= skid_user_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= tail_valid;
                    out_data_reg  <= lane_res;
                    out_user_reg  <= tail_user;
                end
            end else if (tail_valid && en) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= lane_res;
                skid_user_reg  <= tail_user;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = SW'(out_data_reg);
    assign m_tuser  = out_user_reg;

`ifndef NO_ASSERTIONS
    a_sing_no_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_SINGULAR] |-> !m_tuser[USER_CLIPPED])
        else $error("singular result flagged as clipped");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_SINGULAR] |-> m_tdata == '0)
        else $error("singular result with nonzero elements");

    a_skid_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_lanes_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_valid == '0 || lane_valid == '1)
        else $error("divider lanes out of step");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("valid state survived reset");
`endif

endmodule

// ===== tb/matrix3_inverse_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_chk: scoreboard for the 3x3 matrix inverse
// Watches both stream channels, computes the exact inverse of every accepted
// matrix and compares each result transfer against the oldest expectation.
// ----------------------------------------------------------------------------
module matrix3_inverse_chk #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TW         = ((mi3_pkg::NELEM * DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [TW-1:0]              s_tdata,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [TW-1:0]              m_tdata,
    input  logic [mi3_pkg::USER_W-1:0] m_tuser,
    output int                         fail_count,
    output int                         pending
);
    import mi3_pkg::*;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        logic [DATA_WIDTH-1:0] elem [NELEM];
        logic                  singular;
        logic                  clipped;
    } inverse_t;

    inverse_t inverse_q[$];

    function automatic inverse_t invert(logic [TW-1:0] data);
        inverse_t res;
        wide_t    a [NELEM];
        wide_t    cof [NELEM];
        wide_t    det, num, quo, maxpos, minneg;
        int       r, c;
        maxpos = (wide_t'(1) <<< (DATA_WIDTH - 1)) - 1;
        minneg = -(wide_t'(1) <<< (DATA_WIDTH - 1));
        for (int k = 0; k < NELEM; k++)
            a[k] = wide_t'($signed(data[k*DATA_WIDTH +: DATA_WIDTH]));
        det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
            - a[2]*a[4]*a[6] - a[0]*a[5]*a[7] - a[1]*a[3]*a[8];
        res.clipped  = 1'b0;
        res.singular = (det == 0);
        for (int k = 0; k < NELEM; k++) res.elem[k] = '0;
        if (res.singular) return res;
        for (r = 0; r < DIM; r++)
            for (c = 0; c < DIM; c++)
                cof[r*DIM+c] = a[((r+1)%DIM)*DIM + (c+1)%DIM] * a[((r+2)%DIM)*DIM + (c+2)%DIM]
                             - a[((r+1)%DIM)*DIM + (c+2)%DIM] * a[((r+2)%DIM)*DIM + (c+1)%DIM];
        // adjugate is the transposed cofactor matrix; division truncates toward zero
        for (r = 0; r < DIM; r++)
            for (c = 0; c < DIM; c++) begin
                num = cof[c*DIM+r] <<< (2 * FRAC_BITS);
                quo = num / det;
                if (quo > maxpos) begin
                    quo = maxpos;
                    res.clipped = 1'b1;
                end else if (quo < minneg) begin
                    quo = minneg;
                    res.clipped = 1'b1;
                end
                res.elem[r*DIM+c] = quo[DATA_WIDTH-1:0];
            end
        return res;
    endfunction

    assign pending = inverse_q.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        inverse_t exp_res;
        if (aresetn) begin
            if (s_tvalid && s_tready) inverse_q.push_back(invert(s_tdata));
            if (m_tvalid && m_tready) begin
                if (inverse_q.size() == 0) begin
                    $error("result transfer with no matrix outstanding");
                    fail_count++;
                end else begin
                    exp_res = inverse_q.pop_front();
                    for (int k = 0; k < NELEM; k++)
                        if (m_tdata[k*DATA_WIDTH +: DATA_WIDTH] !== exp_res.elem[k]) begin
                            $error("r%0d%0d: expected %h, got %h", k / DIM, k % DIM,
                                   exp_res.elem[k], m_tdata[k*DATA_WIDTH +: DATA_WIDTH]);
                            fail_count++;
                        end
                    if (m_tuser[USER_SINGULAR] !== exp_res.singular) begin
                        $error("singular: expected %b, got %b", exp_res.singular,
                               m_tuser[USER_SINGULAR]);
                        fail_count++;
                    end
                    if (m_tuser[USER_CLIPPED] !== exp_res.clipped) begin
                        $error("clipped: expected %b, got %b", exp_res.clipped,
                               m_tuser[USER_CLIPPED]);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/matrix3_inverse_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_tb: regression for the 3x3 matrix inverse
// Directed corner matrices, then random matrices of mixed magnitude, with
// random gaps on the input side and random backpressure on the result side.
// ----------------------------------------------------------------------------
module matrix3_inverse_tb;
    import mi3_pkg::*;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int TW        = ((NELEM * DW + 7) / 8) * 8;
    localparam int N_RANDOM  = 1600;
    localparam int CYC_LIMIT = 600000;
    localparam logic [DW-1:0] ONE  = 32'h0001_0000;   // 1.0 in Q16.16
    localparam logic [DW-1:0] MAXV = 32'h7fff_ffff;
    localparam logic [DW-1:0] MINV = 32'h8000_0000;

    typedef logic bool_calm_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [TW-1:0]     s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [TW-1:0]     m_tdata;
    logic [USER_W-1:0] m_tuser;
    int                fail_count, pending;
    int                cycles = 0;
    bool_calm_t        calm;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    matrix3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    matrix3_inverse_chk #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // calm stretches: no gaps and no stalls on either side
    always @(negedge aclk) begin
        if (cycles % 300 == 0) calm <= ($urandom_range(0, 3) == 0);
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 65) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side backpressure
    always @(negedge aclk) begin
        if (!aresetn || calm) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 199) == 0);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYC_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one matrix transfer; called at a falling edge, returns at a falling edge
    task automatic send_matrix(input logic [DW-1:0] e [NELEM]);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        for (int k = 0; k < NELEM; k++) s_tdata[k*DW +: DW] <= e[k];
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_diag(input logic [DW-1:0] a, b, c);
        logic [DW-1:0] e [NELEM];
        foreach (e[k]) e[k] = '0;
        e[0] = a; e[4] = b; e[8] = c;
        send_matrix(e);
    endtask

    task automatic send_fill(input logic [DW-1:0] v);
        logic [DW-1:0] e [NELEM];
        foreach (e[k]) e[k] = v;
        send_matrix(e);
    endtask

    // random element at a chosen magnitude class
    function automatic logic [DW-1:0] rnd_elem(int cls);
        case (cls)
            0: return $urandom();
            1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            2: return $signed($urandom_range(0, 512)) - 256;
            default: return ($urandom_range(0, 1) != 0) ? MAXV : MINV;
        endcase
    endfunction

    initial begin
        logic [DW-1:0] e [NELEM];
        int            cls, p;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed corners
        send_diag(ONE, ONE, ONE);               // identity
        send_fill('0);                          // zero matrix, singular
        send_fill(MAXV);                        // rank one, singular
        send_fill(MINV);
        send_diag(MAXV, MAXV, MAXV);
        send_diag(MINV, MINV, MINV);
        send_diag(MINV, MAXV, MINV);
        send_diag(32'd2, ONE, ONE);             // quotient 2^31, clips high
        send_diag(-32'sd2, ONE, ONE);           // quotient exactly -2^31, no clip
        send_diag(-32'sd1, ONE, ONE);           // clips low
        send_diag(32'd1, 32'd1, 32'd1);         // tiny determinant, heavy clipping
        send_diag(ONE << 1, -(ONE << 2), ONE >> 1);
        e = '{ONE, ONE << 1, ONE * 3, ONE << 2, ONE * 5, ONE * 6, ONE * 7, ONE << 3, ONE * 10};
        send_matrix(e);
        e = '{MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, 32'd0};
        send_matrix(e);
        e = '{32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE, ONE, 32'd0, 32'd0};  // permutation
        send_matrix(e);
        e = '{32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'hdead_beef,
              32'h0f0f_0f0f, 32'hf0f0_f0f0, 32'h0000_0001, 32'h8000_0001};
        send_matrix(e);

        // random matrices
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // drain the pipe before going on
                s_tvalid <= 1'b0;
                while (pending != 0) @(negedge aclk);
            end
            p = $urandom_range(0, 99);
            foreach (e[k]) begin
                cls = (p < 30) ? 0 : (p < 60) ? 1 : (p < 85) ? 2 : $urandom_range(0, 3);
                e[k] = rnd_elem(cls);
            end
            if (p >= 92) begin
                // duplicate a row or column: singular
                if ($urandom_range(0, 1) != 0)
                    for (int c = 0; c < DIM; c++) e[DIM + c] = e[c];
                else
                    for (int r = 0; r < DIM; r++) e[r*DIM + 2] = e[r*DIM];
            end
            send_matrix(e);
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DW + 30) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
